// File: hw/rtl/hap_pkg.sv
// hap_pkg: sizes, request and status codes for the hole allocator.
// No dependencies; imported by hole_allocator_with_paging.
package hap_pkg;

    localparam int SPACE_BYTES = 1024;
    localparam int PAGE_BYTES  = 16;
    localparam int PAGE_COUNT  = 64;
    localparam int FRAME_COUNT = 64;
    localparam int MAX_HOLES   = 16;

    localparam int AW   = $clog2(SPACE_BYTES);   // virtual address bits
    localparam int LW   = AW + 1;                // length bits
    localparam int OFFW = $clog2(PAGE_BYTES);    // byte offset in a page
    localparam int PGW  = $clog2(PAGE_COUNT);    // page index bits
    localparam int FW   = $clog2(FRAME_COUNT);   // frame index bits
    localparam int PHW  = FW + OFFW;             // physical address bits
    localparam int HIW  = $clog2(MAX_HOLES);     // hole index bits
    localparam int HCW  = HIW + 1;               // hole count bits

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_WRITE = 2'd2,
        REQ_READ  = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOFIT    = 3'd1,
        ST_NOFRAME  = 3'd2,
        ST_FULL     = 3'd3,
        ST_UNMAPPED = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2,
        FIT_ALT   = 2'd3
    } fit_t;

    localparam logic REG_FIT_POLICY = 1'b0;

endpackage

// File: hw/rtl/hap_ram.sv
// hap_ram: generic single-port RAM, registered read, read-before-write.
// No dependencies.
module hap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: hw/rtl/hole_allocator_with_paging.sv
// hole_allocator_with_paging: free-hole allocator with page table and byte store.
// Depends on hap_pkg and hap_ram.
//
//  - Request channel (s_*): one beat = req_type, address, length, write_data.
//    Allocate takes a hole chosen by fit_policy and maps its pages to the lowest
//    free frames; free returns a range and coalesces; write/read move one byte.
//  - Result channel (m_*): one beat per request (status, alloc_address,
//    read_data) from an output register; s_ready returns once the sequencer is
//    idle, even while that result is still waiting.
//  - APB: register 0 (byte address 0) is fit_policy, 2 bits, reset 1. Write it
//    only while no request is in flight.
//  - One request at a time, s_ready low meanwhile; the sequencer steps are:
//      allocate : scan every hole, count unmapped pages, check free frames, shift
//                 the holes above the pick when it is used up exactly, map pages
//      free     : find the hole position, read both neighbours, merge, shift the
//                 table on an insert or a double merge, release each covered page
//      write    : page lookup, then byte store; read adds a read step; zero-length
//                 allocate and free go straight to the result
//  - Reset (aresetn low, synchronous): one hole over the whole space, no page
//    mapped, all frames free, best fit. Byte store is not cleared.
//  - Receiver stall: a finished result waits in the final state until the
//    output register frees up.
module hole_allocator_with_paging
    import hap_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    // request channel
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [1:0]    s_req_type,
    input  logic [AW-1:0] s_address,
    input  logic [LW-1:0] s_length,
    input  logic [7:0]    s_write_data,
    // result channel
    output logic          m_valid,
    input  logic          m_ready,
    output logic [2:0]    m_status,
    output logic [AW-1:0] m_alloc_address,
    output logic [7:0]    m_read_data,
    // configuration
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [0:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    typedef enum logic [18:0] {
        S_IDLE   = 19'd1 << 0,
        S_APICK  = 19'd1 << 1,
        S_ANEED  = 19'd1 << 2,
        S_ACHECK = 19'd1 << 3,
        S_ASHIFT = 19'd1 << 4,
        S_AMAP   = 19'd1 << 5,
        S_FFIND  = 19'd1 << 6,
        S_FPREV  = 19'd1 << 7,
        S_FNEXT  = 19'd1 << 8,
        S_FMERGE = 19'd1 << 9,
        S_FSHDN  = 19'd1 << 10,
        S_FSHUP  = 19'd1 << 11,
        S_FRSET  = 19'd1 << 12,
        S_FREL   = 19'd1 << 13,
        S_FRELW  = 19'd1 << 14,
        S_XPAGE  = 19'd1 << 15,
        S_XMEM   = 19'd1 << 16,
        S_XRD    = 19'd1 << 17,
        S_DONE   = 19'd1 << 18
    } state_t;

    state_t        state_reg, state_next;
    req_t          req_reg, req_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [LW-1:0] len_reg, len_next;
    logic [7:0]    wdata_reg, wdata_next;
    logic [1:0]    fit_reg;

    // hole table
    logic [AW-1:0]  hole_start_reg [MAX_HOLES];
    logic [AW-1:0]  hole_start_next [MAX_HOLES];
    logic [LW-1:0]  hole_len_reg [MAX_HOLES];
    logic [LW-1:0]  hole_len_next [MAX_HOLES];
    logic [HCW-1:0] hole_count_reg, hole_count_next;

    // page / frame bookkeeping
    logic [PAGE_COUNT-1:0]  page_valid_reg, page_valid_next;
    logic [FRAME_COUNT-1:0] frame_used_reg, frame_used_next;
    logic [FW:0]            free_cnt_reg, free_cnt_next;

    // sequencer scratch
    logic [HCW-1:0] idx_reg, idx_next;
    logic [HCW-1:0] k_reg, k_next;
    logic           found_reg, found_next;
    logic [HIW-1:0] pick_reg, pick_next;
    logic [AW-1:0]  pick_start_reg, pick_start_next;
    logic [LW-1:0]  pick_len_reg, pick_len_next;
    logic [PGW-1:0] last_reg, last_next;
    logic [PGW:0]   p_reg, p_next;
    logic [PGW:0]   need_reg, need_next;
    logic [FW:0]    f_reg, f_next;
    logic           mprev_reg, mprev_next;
    logic           mnext_reg, mnext_next;
    logic [AW-1:0]  prev_start_reg, prev_start_next;
    logic [LW-1:0]  prev_len_reg, prev_len_next;
    logic [LW-1:0]  next_len_reg, next_len_next;
    logic [AW-1:0]  beg_reg, beg_next;
    logic [LW-1:0]  end_reg, end_next;

    // pending result
    status_t       res_status_reg, res_status_next;
    logic [AW-1:0] res_addr_reg, res_addr_next;
    logic [7:0]    res_rdata_reg, res_rdata_next;

    // output register
    logic          m_valid_reg, m_valid_next;
    logic [2:0]    m_status_reg, m_status_next;
    logic [AW-1:0] m_addr_reg, m_addr_next;
    logic [7:0]    m_rdata_reg, m_rdata_next;

    // shared hole-table read port
    logic [HIW-1:0] hrd_idx;
    logic [AW-1:0]  hrd_start;
    logic [LW-1:0]  hrd_len;

    // RAM ports
    logic           pg_we;
    logic [PGW-1:0] pg_addr;
    logic [FW-1:0]  pg_wdata, pg_rdata;
    logic           mem_we;
    logic [PHW-1:0] mem_addr;
    logic [7:0]     mem_rdata;

    logic           cfg_wr;
    logic [LW-1:0]  a_end, lim, sum3, sum2, rel_top;
    logic [PGW:0]   rel_first;

    assign s_ready         = (state_reg == S_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_alloc_address = m_addr_reg;
    assign m_read_data     = m_rdata_reg;
    assign pready          = 1'b1;
    assign cfg_wr          = psel && penable && pwrite && (paddr == REG_FIT_POLICY);
    assign prdata          = (paddr == REG_FIT_POLICY) ? 32'(fit_reg) : 32'd0;

    assign hrd_start = hole_start_reg[hrd_idx];
    assign hrd_len   = hole_len_reg[hrd_idx];

    // last byte of the picked range, page-clipped begin of the merged hole
    assign a_end     = {1'b0, pick_start_reg} + len_reg - LW'(1);
    assign lim       = LW'(SPACE_BYTES) - {1'b0, s_address};
    assign sum2      = prev_len_reg + len_reg;
    assign sum3      = sum2 + next_len_reg;
    assign rel_first = (PGW+1)'(({1'b0, beg_reg} + LW'(PAGE_BYTES - 1)) >> OFFW);
    assign rel_top   = {p_reg + 1'b1, OFFW'(0)};

    always_comb begin
        case (state_reg)
            S_ASHIFT: hrd_idx = HIW'(idx_reg + 1'b1);
            S_FPREV:  hrd_idx = HIW'(idx_reg - 1'b1);
            S_FSHDN:  hrd_idx = HIW'(k_reg + 1'b1);
            S_FSHUP:  hrd_idx = HIW'(k_reg - 1'b1);
            default:  hrd_idx = idx_reg[HIW-1:0];
        endcase
    end

    hap_ram #(.WIDTH(FW), .DEPTH(PAGE_COUNT)) u_page_map (
        .aclk  (aclk),
        .we    (pg_we),
        .addr  (pg_addr),
        .wdata (pg_wdata),
        .rdata (pg_rdata)
    );

    hap_ram #(.WIDTH(8), .DEPTH(FRAME_COUNT * PAGE_BYTES)) u_byte_store (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (wdata_reg),
        .rdata (mem_rdata)
    );

    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        addr_next       = addr_reg;
        len_next        = len_reg;
        wdata_next      = wdata_reg;
        hole_start_next = hole_start_reg;
        hole_len_next   = hole_len_reg;
        hole_count_next = hole_count_reg;
        page_valid_next = page_valid_reg;
        frame_used_next = frame_used_reg;
        free_cnt_next   = free_cnt_reg;
        idx_next        = idx_reg;
        k_next          = k_reg;
        found_next      = found_reg;
        pick_next       = pick_reg;
        pick_start_next = pick_start_reg;
        pick_len_next   = pick_len_reg;
        last_next       = last_reg;
        p_next          = p_reg;
        need_next       = need_reg;
        f_next          = f_reg;
        mprev_next      = mprev_reg;
        mnext_next      = mnext_reg;
        prev_start_next = prev_start_reg;
        prev_len_next   = prev_len_reg;
        next_len_next   = next_len_reg;
        beg_next        = beg_reg;
        end_next        = end_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_rdata_next  = res_rdata_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_addr_next     = m_addr_reg;
        m_rdata_next    = m_rdata_reg;
        pg_we           = 1'b0;
        pg_addr         = p_reg[PGW-1:0];
        pg_wdata        = f_reg[FW-1:0];
        mem_we          = 1'b0;
        mem_addr        = {pg_rdata, addr_reg[OFFW-1:0]};

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next        = req_t'(s_req_type);
                    addr_next       = s_address;
                    len_next        = s_length;
                    wdata_next      = s_write_data;
                    res_status_next = ST_OK;
                    res_addr_next   = '0;
                    res_rdata_next  = '0;
                    idx_next        = '0;
                    found_next      = 1'b0;
                    case (req_t'(s_req_type))
                        REQ_ALLOC: begin
                            if (s_length == '0) begin
                                res_status_next = ST_NOFIT;
                                state_next      = S_DONE;
                            end else begin
                                state_next = S_APICK;
                            end
                        end
                        REQ_FREE: begin
                            if (s_length == '0) begin
                                state_next = S_DONE;
                            end else begin
                                if (s_length > lim) begin
                                    len_next = lim;
                                end
                                state_next = S_FFIND;
                            end
                        end
                        default: state_next = S_XPAGE;
                    endcase
                end
            end

            // scan holes for the fit
            S_APICK: begin
                if (idx_reg >= hole_count_reg) begin
                    if (!found_reg) begin
                        res_status_next = ST_NOFIT;
                        state_next      = S_DONE;
                    end else begin
                        p_next     = {1'b0, pick_start_reg[AW-1:OFFW]};
                        last_next  = a_end[AW-1:OFFW];
                        need_next  = '0;
                        state_next = S_ANEED;
                    end
                end else begin
                    if (hrd_len >= len_reg) begin
                        if (!found_reg
                            || (fit_reg == FIT_WORST && hrd_len > pick_len_reg)
                            || (fit_reg != FIT_WORST && fit_reg != FIT_FIRST
                                && hrd_len < pick_len_reg)) begin
                            found_next      = 1'b1;
                            pick_next       = idx_reg[HIW-1:0];
                            pick_start_next = hrd_start;
                            pick_len_next   = hrd_len;
                        end
                    end
                    idx_next = idx_reg + 1'b1;
                end
            end

            // count unmapped pages of the range
            S_ANEED: begin
                if (p_reg > {1'b0, last_reg}) begin
                    state_next = S_ACHECK;
                end else begin
                    if (!page_valid_reg[p_reg[PGW-1:0]]) begin
                        need_next = need_reg + 1'b1;
                    end
                    p_next = p_reg + 1'b1;
                end
            end

            S_ACHECK: begin
                if ((FW+1)'(need_reg) > free_cnt_reg) begin
                    res_status_next = ST_NOFRAME;
                    state_next      = S_DONE;
                end else if (pick_len_reg == len_reg) begin
                    idx_next   = {1'b0, pick_reg};
                    state_next = S_ASHIFT;
                end else begin
                    hole_start_next[pick_reg] = AW'({1'b0, pick_start_reg} + len_reg);
                    hole_len_next[pick_reg]   = pick_len_reg - len_reg;
                    p_next     = {1'b0, pick_start_reg[AW-1:OFFW]};
                    f_next     = '0;
                    state_next = S_AMAP;
                end
            end

            // close the gap left by a fully used hole
            S_ASHIFT: begin
                if (idx_reg + 1'b1 < hole_count_reg) begin
                    hole_start_next[idx_reg[HIW-1:0]] = hrd_start;
                    hole_len_next[idx_reg[HIW-1:0]]   = hrd_len;
                    idx_next = idx_reg + 1'b1;
                end else begin
                    hole_count_next = hole_count_reg - 1'b1;
                    p_next     = {1'b0, pick_start_reg[AW-1:OFFW]};
                    f_next     = '0;
                    state_next = S_AMAP;
                end
            end

            // map each unmapped page to the lowest free frame
            S_AMAP: begin
                if (p_reg > {1'b0, last_reg}) begin
                    res_addr_next = pick_start_reg;
                    state_next    = S_DONE;
                end else if (page_valid_reg[p_reg[PGW-1:0]]) begin
                    p_next = p_reg + 1'b1;
                end else if (frame_used_reg[f_reg[FW-1:0]]) begin
                    f_next = f_reg + 1'b1;
                end else begin
                    pg_we = 1'b1;
                    frame_used_next[f_reg[FW-1:0]] = 1'b1;
                    page_valid_next[p_reg[PGW-1:0]] = 1'b1;
                    free_cnt_next = free_cnt_reg - 1'b1;
                    p_next        = p_reg + 1'b1;
                end
            end

            // first hole whose start is not below the freed address
            S_FFIND: begin
                if (idx_reg < hole_count_reg && addr_reg > hrd_start) begin
                    idx_next = idx_reg + 1'b1;
                end else begin
                    state_next = S_FPREV;
                end
            end

            S_FPREV: begin
                mprev_next      = (idx_reg != '0)
                                  && ({1'b0, hrd_start} + hrd_len == {1'b0, addr_reg});
                prev_start_next = hrd_start;
                prev_len_next   = hrd_len;
                state_next      = S_FNEXT;
            end

            S_FNEXT: begin
                mnext_next    = (idx_reg < hole_count_reg)
                                && ({1'b0, addr_reg} + len_reg == {1'b0, hrd_start});
                next_len_next = hrd_len;
                state_next    = S_FMERGE;
            end

            S_FMERGE: begin
                if (mprev_reg && mnext_reg) begin
                    hole_len_next[HIW'(idx_reg - 1'b1)] = sum3;
                    beg_next   = prev_start_reg;
                    end_next   = {1'b0, prev_start_reg} + sum3;
                    k_next     = idx_reg;
                    state_next = S_FSHDN;
                end else if (mprev_reg) begin
                    hole_len_next[HIW'(idx_reg - 1'b1)] = sum2;
                    beg_next   = prev_start_reg;
                    end_next   = {1'b0, prev_start_reg} + sum2;
                    state_next = S_FRSET;
                end else if (mnext_reg) begin
                    hole_start_next[idx_reg[HIW-1:0]] = addr_reg;
                    hole_len_next[idx_reg[HIW-1:0]]   = next_len_reg + len_reg;
                    beg_next   = addr_reg;
                    end_next   = {1'b0, addr_reg} + next_len_reg + len_reg;
                    state_next = S_FRSET;
                end else if (hole_count_reg >= HCW'(MAX_HOLES)) begin
                    res_status_next = ST_FULL;
                    state_next      = S_DONE;
                end else begin
                    beg_next   = addr_reg;
                    end_next   = {1'b0, addr_reg} + len_reg;
                    k_next     = hole_count_reg;
                    state_next = S_FSHUP;
                end
            end

            // both neighbors merged: drop the upper one
            S_FSHDN: begin
                if (k_reg + 1'b1 < hole_count_reg) begin
                    hole_start_next[k_reg[HIW-1:0]] = hrd_start;
                    hole_len_next[k_reg[HIW-1:0]]   = hrd_len;
                    k_next = k_reg + 1'b1;
                end else begin
                    hole_count_next = hole_count_reg - 1'b1;
                    state_next      = S_FRSET;
                end
            end

            // open a slot for a new hole
            S_FSHUP: begin
                if (k_reg > idx_reg) begin
                    hole_start_next[k_reg[HIW-1:0]] = hrd_start;
                    hole_len_next[k_reg[HIW-1:0]]   = hrd_len;
                    k_next = k_reg - 1'b1;
                end else begin
                    hole_start_next[idx_reg[HIW-1:0]] = addr_reg;
                    hole_len_next[idx_reg[HIW-1:0]]   = len_reg;
                    hole_count_next = hole_count_reg + 1'b1;
                    state_next      = S_FRSET;
                end
            end

            S_FRSET: begin
                p_next     = rel_first;
                state_next = S_FREL;
            end

            // release pages fully inside the merged hole
            S_FREL: begin
                if (p_reg < (PGW+1)'(PAGE_COUNT) && rel_top <= end_reg) begin
                    if (page_valid_reg[p_reg[PGW-1:0]]) begin
                        state_next = S_FRELW;
                    end else begin
                        p_next = p_reg + 1'b1;
                    end
                end else begin
                    state_next = S_DONE;
                end
            end

            S_FRELW: begin
                frame_used_next[pg_rdata]        = 1'b0;
                page_valid_next[p_reg[PGW-1:0]]  = 1'b0;
                free_cnt_next = free_cnt_reg + 1'b1;
                p_next        = p_reg + 1'b1;
                state_next    = S_FREL;
            end

            S_XPAGE: begin
                pg_addr = addr_reg[AW-1:OFFW];
                if (!page_valid_reg[addr_reg[AW-1:OFFW]]) begin
                    res_status_next = ST_UNMAPPED;
                    state_next      = S_DONE;
                end else begin
                    state_next = S_XMEM;
                end
            end

            S_XMEM: begin
                pg_addr = addr_reg[AW-1:OFFW];
                if (req_reg == REQ_WRITE) begin
                    mem_we     = 1'b1;
                    state_next = S_DONE;
                end else begin
                    state_next = S_XRD;
                end
            end

            S_XRD: begin
                res_rdata_next = mem_rdata;
                state_next     = S_DONE;
            end

            // hand the result to the output register
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_addr_next   = res_addr_reg;
                    m_rdata_next  = res_rdata_reg;
                    state_next    = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            fit_reg        <= FIT_BEST;
            hole_count_reg <= HCW'(1);
            page_valid_reg <= '0;
            frame_used_reg <= '0;
            free_cnt_reg   <= (FW+1)'(FRAME_COUNT);
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < MAX_HOLES; i++) begin
                hole_start_reg[i] <= '0;
                hole_len_reg[i]   <= '0;
            end
            hole_len_reg[0] <= LW'(SPACE_BYTES);
        end else begin
            state_reg      <= state_next;
            hole_count_reg <= hole_count_next;
            page_valid_reg <= page_valid_next;
            frame_used_reg <= frame_used_next;
            free_cnt_reg   <= free_cnt_next;
            m_valid_reg    <= m_valid_next;
            hole_start_reg <= hole_start_next;
            hole_len_reg   <= hole_len_next;
            if (cfg_wr) begin
                fit_reg <= pwdata[1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        addr_reg       <= addr_next;
        len_reg        <= len_next;
        wdata_reg      <= wdata_next;
        idx_reg        <= idx_next;
        k_reg          <= k_next;
        found_reg      <= found_next;
        pick_reg       <= pick_next;
        pick_start_reg <= pick_start_next;
        pick_len_reg   <= pick_len_next;
        last_reg       <= last_next;
        p_reg          <= p_next;
        need_reg       <= need_next;
        f_reg          <= f_next;
        mprev_reg      <= mprev_next;
        mnext_reg      <= mnext_next;
        prev_start_reg <= prev_start_next;
        prev_len_reg   <= prev_len_next;
        next_len_reg   <= next_len_next;
        beg_reg        <= beg_next;
        end_reg        <= end_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_rdata_reg  <= res_rdata_next;
        m_status_reg   <= m_status_next;
        m_addr_reg     <= m_addr_next;
        m_rdata_reg    <= m_rdata_next;
    end

    // free-frame counter tracks the used-frame flags
    a_free_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(free_cnt_reg) + $countones(frame_used_reg)) == FRAME_COUNT)
        else $error("free frame count out of step with frame flags");

    // every mapped page owns exactly one frame
    a_map_frames: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(page_valid_reg) == $countones(frame_used_reg))
        else $error("mapped pages and used frames disagree");

    a_hole_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        hole_count_reg <= HCW'(MAX_HOLES))
        else $error("hole count above table size");

    // one request at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken while busy");

endmodule

// File: sim/testbench.sv
// Testbench for hole_allocator_with_paging: directed table, then random traffic per fit policy.
// Depends on hap_pkg and the RTL of hole_allocator_with_paging; self-checking, no files read.
`timescale 1ns / 100ps

module testbench;
    import hap_pkg::*;

    // ---------------------------------------------------------------
    // DUT signals; every input starts from a known value
    // ---------------------------------------------------------------
    logic          aclk;
    logic          aresetn      = 1'b0;
    logic          s_valid      = 1'b0;
    logic          s_ready;
    logic [1:0]    s_req_type   = '0;
    logic [AW-1:0] s_address    = '0;
    logic [LW-1:0] s_length     = '0;
    logic [7:0]    s_write_data = '0;
    logic          m_valid;
    logic          m_ready      = 1'b0;
    logic [2:0]    m_status;
    logic [AW-1:0] m_alloc_address;
    logic [7:0]    m_read_data;
    logic          psel         = 1'b0;
    logic          penable      = 1'b0;
    logic          pwrite       = 1'b0;
    logic [0:0]    paddr        = '0;
    logic [31:0]   pwdata       = '0;
    logic [31:0]   prdata;
    logic          pready;

    hole_allocator_with_paging uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_address(s_address), .s_length(s_length), .s_write_data(s_write_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_alloc_address(m_alloc_address), .m_read_data(m_read_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Hard stop: far beyond any request plus its stalls.
    initial begin
        #20000000;
        $display("Verification failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Shadow allocator state
    // ---------------------------------------------------------------
    typedef struct {
        status_t       st;
        logic [AW-1:0] aa;
        logic [7:0]    rd;
    } reply_t;

    typedef struct {
        int start;
        int len;
    } span_t;

    int          hs[MAX_HOLES];          // hole start
    int          hl[MAX_HOLES];          // hole length
    int          hcnt;
    bit [FW-1:0] pframe[PAGE_COUNT];
    bit          pvalid[PAGE_COUNT];
    bit          fused[FRAME_COUNT];
    logic [7:0]  phys_mem[FRAME_COUNT*PAGE_BYTES];
    bit          phys_written[FRAME_COUNT*PAGE_BYTES];
    fit_t        fit_cfg;

    reply_t pending_replies[$];
    span_t  live_spans[$];               // ranges handed out, used to aim frees and accesses
    int     err_count = 0;
    bit     calm = 1'b0;                 // no idling on either side
    int     stall_left = 0;

    function automatic int pick_hole_idx(int len);
        int pick = -1;
        for (int i = 0; i < hcnt; i++) begin
            if (hl[i] < len) continue;
            if (pick < 0) begin
                pick = i;
                if (fit_cfg == FIT_FIRST) return pick;
            end else if (fit_cfg == FIT_WORST) begin
                if (hl[i] > hl[pick]) pick = i;
            end else if (hl[i] < hl[pick]) begin
                pick = i;   // best fit, and the spare code behaves the same
            end
        end
        return pick;
    endfunction

    function automatic void predict_alloc(int len, output status_t st, output int a);
        int h, first, last, need, avail, f;
        a = 0; need = 0; avail = 0; f = 0;
        st = ST_NOFIT;
        if (len == 0) return;
        h = pick_hole_idx(len);
        if (h < 0) return;
        first = hs[h] / PAGE_BYTES;
        last  = (hs[h] + len - 1) / PAGE_BYTES;
        for (int p = first; p <= last && p < PAGE_COUNT; p++)
            if (!pvalid[p]) need++;
        for (int p = 0; p < FRAME_COUNT; p++)
            if (!fused[p]) avail++;
        if (need > avail) begin
            st = ST_NOFRAME;
            return;
        end
        a = hs[h];
        if (hl[h] == len) begin
            for (int i = h; i + 1 < hcnt; i++) begin
                hs[i] = hs[i+1];
                hl[i] = hl[i+1];
            end
            hcnt--;
        end else begin
            hs[h] += len;
            hl[h] -= len;
        end
        // map each unmapped page to the lowest free frame
        for (int p = first; p <= last && p < PAGE_COUNT; p++) begin
            if (pvalid[p]) continue;
            while (f < FRAME_COUNT && fused[f]) f++;
            if (f >= FRAME_COUNT) break;
            fused[f]  = 1'b1;
            pframe[p] = f[FW-1:0];
            pvalid[p] = 1'b1;
        end
        st = ST_OK;
    endfunction

    function automatic status_t predict_free(int addr, int len);
        int i = 0;
        int k, lo, hi;
        bit mprev, mnext;
        if (len == 0 || addr >= SPACE_BYTES) return ST_OK;
        if (len > SPACE_BYTES - addr) len = SPACE_BYTES - addr;
        while (i < hcnt && addr > hs[i]) i++;
        mprev = (i > 0) && (hs[i-1] + hl[i-1] == addr);
        mnext = (i < hcnt) && (addr + len == hs[i]);
        if (mprev && mnext) begin
            hl[i-1] += len + hl[i];
            for (k = i; k + 1 < hcnt; k++) begin
                hs[k] = hs[k+1];
                hl[k] = hl[k+1];
            end
            hcnt--;
            k = i - 1;
        end else if (mprev) begin
            hl[i-1] += len;
            k = i - 1;
        end else if (mnext) begin
            hs[i] = addr;
            hl[i] += len;
            k = i;
        end else begin
            if (hcnt >= MAX_HOLES) return ST_FULL;
            for (k = hcnt; k > i; k--) begin
                hs[k] = hs[k-1];
                hl[k] = hl[k-1];
            end
            hs[i] = addr;
            hl[i] = len;
            hcnt++;
            k = i;
        end
        // release pages that the merged hole covers completely
        lo = hs[k];
        hi = lo + hl[k];
        for (int p = (lo + PAGE_BYTES - 1) / PAGE_BYTES;
             p < PAGE_COUNT && (p + 1) * PAGE_BYTES <= hi; p++) begin
            if (pvalid[p]) begin
                fused[pframe[p]] = 1'b0;
                pvalid[p] = 1'b0;
            end
        end
        return ST_OK;
    endfunction

    function automatic bit page_lookup(int addr, output int phys);
        int p = addr / PAGE_BYTES;
        phys = 0;
        if (p >= PAGE_COUNT || !pvalid[p]) return 1'b0;
        phys = int'(pframe[p]) * PAGE_BYTES + addr % PAGE_BYTES;
        return 1'b1;
    endfunction

    function automatic reply_t predict_request(req_t rq, int addr, int len, logic [7:0] wd);
        reply_t r;
        int a, phys;
        status_t st;
        r.st = ST_OK; r.aa = '0; r.rd = '0;
        case (rq)
            REQ_ALLOC: begin
                predict_alloc(len, st, a);
                r.st = st;
                if (st == ST_OK) r.aa = a[AW-1:0];
            end
            REQ_FREE:  r.st = predict_free(addr, len);
            REQ_WRITE: begin
                if (page_lookup(addr, phys)) begin
                    phys_mem[phys]     = wd;
                    phys_written[phys] = 1'b1;
                end else begin
                    r.st = ST_UNMAPPED;
                end
            end
            default: begin
                if (page_lookup(addr, phys)) r.rd = phys_mem[phys];
                else r.st = ST_UNMAPPED;
            end
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------
    // Raise valid with the payload, hold until the accepting edge, then predict.
    // Returns at that edge; the caller drives the next beat or drops valid.
    task automatic send_req(req_t rq, int ad, int ln, logic [7:0] wd, output reply_t pred);
        s_valid      <= 1'b1;
        s_req_type   <= rq;
        s_address    <= ad[AW-1:0];
        s_length     <= ln[LW-1:0];
        s_write_data <= wd;
        do @(posedge aclk); while (!s_ready);
        pred = predict_request(rq, ad, ln, wd);
    endtask

    task automatic wait_drained();
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (250) @(posedge aclk);
    endtask

    // APB write then read-back of the policy register
    task automatic set_fit(fit_t v);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= REG_FIT_POLICY; pwdata <= 32'(v);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        pwrite <= 1'b0; penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== 32'(v)) begin
            $display("%0t: fit_policy read-back expected %0d actual %0d", $time, v, prdata);
            err_count++;
        end
        psel <= 1'b0; penable <= 1'b0;
        fit_cfg = v;
    endtask

    // Address inside a live range most of the time, anywhere otherwise
    function automatic int pick_access_addr();
        span_t sp;
        if (live_spans.size() != 0 && $urandom_range(0, 9) < 8) begin
            sp = live_spans[$urandom_range(0, live_spans.size() - 1)];
            return (sp.start + $urandom_range(0, sp.len - 1)) % SPACE_BYTES;
        end
        return $urandom_range(0, SPACE_BYTES - 1);
    endfunction

    task automatic run_random(int count);
        reply_t pred;
        req_t rq;
        span_t sp;
        int ad, ln, r, idx, phys;
        logic [7:0] wd;
        for (int n = 0; n < count; n++) begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
            r  = $urandom_range(0, 99);
            ad = 0; ln = 0;
            wd = $urandom_range(0, 255);
            if (r < 38) begin
                rq = REQ_ALLOC;
                if ($urandom_range(0, 19) == 0) begin
                    case ($urandom_range(0, 3))
                        0: ln = 0;
                        1: ln = SPACE_BYTES;
                        2: ln = 2047;
                        default: ln = $urandom_range(0, 2047);
                    endcase
                end else begin
                    ln = $urandom_range(1, 48);
                end
            end else if (r < 62) begin
                rq = REQ_FREE;
                if (live_spans.size() != 0 && $urandom_range(0, 9) < 8) begin
                    idx = $urandom_range(0, live_spans.size() - 1);
                    sp  = live_spans[idx];
                    ad  = sp.start;
                    ln  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, sp.len) : sp.len;
                    live_spans.delete(idx);
                end else begin
                    // stray free: overlapping, clipped or zero length
                    ad = $urandom_range(0, SPACE_BYTES - 1);
                    ln = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
                                                      : $urandom_range(0, 40);
                end
            end else begin
                rq = (r < 82) ? REQ_WRITE : REQ_READ;
                ad = pick_access_addr();
                // a mapped byte never written must not be read back
                if (rq == REQ_READ && page_lookup(ad, phys) && !phys_written[phys])
                    rq = REQ_WRITE;
            end
            send_req(rq, ad, ln, wd, pred);
            pending_replies.push_back(pred);
            if (rq == REQ_ALLOC && pred.st == ST_OK)
                live_spans.push_back('{start: int'(pred.aa), len: ln});
        end
        s_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Directed table: typed expectations where obvious, predictor otherwise
    // ---------------------------------------------------------------
    typedef struct {
        req_t          rq;
        int            ad;
        int            ln;
        logic [7:0]    wd;
        bit            typed;
        status_t       st;
        logic [AW-1:0] aa;
        logic [7:0]    rd;
    } row_t;

    row_t dir_rows[$];

    initial begin
        reply_t pred, want;
        dir_rows = '{
            '{REQ_READ,     0,    0, 8'h00, 1, ST_UNMAPPED, 10'd0,   8'h00}, // nothing mapped
            '{REQ_WRITE,    0,    0, 8'h55, 1, ST_UNMAPPED, 10'd0,   8'h00},
            '{REQ_ALLOC,    0,    0, 8'h00, 1, ST_NOFIT,    10'd0,   8'h00}, // zero length
            '{REQ_ALLOC,    0, 2047, 8'h00, 1, ST_NOFIT,    10'd0,   8'h00}, // longer than space
            '{REQ_ALLOC, 1023, 1024, 8'h00, 1, ST_OK,       10'd0,   8'h00}, // whole space
            '{REQ_ALLOC,    0,    1, 8'h00, 1, ST_NOFIT,    10'd0,   8'h00}, // table empty
            '{REQ_WRITE, 1023,    0, 8'hFF, 1, ST_OK,       10'd0,   8'h00},
            '{REQ_READ,  1023,    0, 8'h00, 1, ST_OK,       10'd0,   8'hFF},
            '{REQ_WRITE,    0,    0, 8'h00, 1, ST_OK,       10'd0,   8'h00},
            '{REQ_READ,     0,    0, 8'h00, 1, ST_OK,       10'd0,   8'h00},
            '{REQ_FREE,     0,    0, 8'h00, 1, ST_OK,       10'd0,   8'h00}, // zero length
            '{REQ_FREE,  1000, 2047, 8'h00, 1, ST_OK,       10'd0,   8'h00}, // clipped, empty table
            '{REQ_READ,  1023,    0, 8'h00, 1, ST_UNMAPPED, 10'd0,   8'h00}, // last page released
            '{REQ_FREE,     0, 1000, 8'h00, 1, ST_OK,       10'd0,   8'h00}, // merges up
            '{REQ_READ,     0,    0, 8'h00, 1, ST_UNMAPPED, 10'd0,   8'h00},
            '{REQ_ALLOC,    0,  100, 8'h00, 1, ST_OK,       10'd0,   8'h00},
            '{REQ_ALLOC,    0,    1, 8'h00, 1, ST_OK,       10'd100, 8'h00},
            '{REQ_FREE,     0,   50, 8'h00, 1, ST_OK,       10'd0,   8'h00},
            '{REQ_ALLOC,    0,   40, 8'h00, 0, ST_OK,       10'd0,   8'h00}, // best fit choice
            '{REQ_WRITE, 1023,    0, 8'h3C, 0, ST_OK,       10'd0,   8'h00},
            '{REQ_WRITE,   37,    0, 8'hA5, 0, ST_OK,       10'd0,   8'h00},
            '{REQ_READ,    37,    0, 8'h00, 0, ST_OK,       10'd0,   8'h00},
            '{REQ_ALLOC,    0,   10, 8'h00, 0, ST_OK,       10'd0,   8'h00},
            '{REQ_FREE,  1023,    1, 8'h00, 0, ST_OK,       10'd0,   8'h00}
        };

        // shadow reset
        for (int i = 0; i < MAX_HOLES; i++) begin
            hs[i] = 0;
            hl[i] = 0;
        end
        hl[0] = SPACE_BYTES;
        hcnt  = 1;
        for (int p = 0; p < PAGE_COUNT; p++) begin
            pframe[p] = '0;
            pvalid[p] = 1'b0;
        end
        for (int f = 0; f < FRAME_COUNT; f++) fused[f] = 1'b0;
        for (int b = 0; b < FRAME_COUNT * PAGE_BYTES; b++) begin
            phys_mem[b]     = 8'h00;
            phys_written[b] = 1'b0;
        end
        fit_cfg = FIT_BEST;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part runs at the reset policy (best fit)
        foreach (dir_rows[i]) begin
            send_req(dir_rows[i].rq, dir_rows[i].ad, dir_rows[i].ln, dir_rows[i].wd, pred);
            if (dir_rows[i].typed) begin
                want.st = dir_rows[i].st;
                want.aa = dir_rows[i].aa;
                want.rd = dir_rows[i].rd;
                pending_replies.push_back(want);
            end else begin
                pending_replies.push_back(pred);
            end
        end
        s_valid <= 1'b0;
        wait_drained();   // sender holds off until every reply is in

        // one phase per policy, ending on the reset value with idling off
        set_fit(FIT_FIRST);
        run_random(270);
        wait_drained();
        set_fit(FIT_WORST);
        run_random(270);
        wait_drained();
        set_fit(FIT_ALT);
        run_random(200);
        wait_drained();
        set_fit(FIT_BEST);
        run_random(200);
        calm = 1'b1;
        run_random(150);
        wait_drained();

        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // ---------------------------------------------------------------
    // Result side: random stall bursts, compare each beat with the oldest reply
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        reply_t want;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_replies.size() == 0) begin
                    $display("%0t: unexpected result beat status %0d", $time, m_status);
                    err_count++;
                end else begin
                    want = pending_replies.pop_front();
                    if (m_status !== want.st) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.st, m_status);
                        err_count++;
                    end
                    if (m_alloc_address !== want.aa) begin
                        $display("%0t: alloc_address expected %0d actual %0d",
                                 $time, want.aa, m_alloc_address);
                        err_count++;
                    end
                    if (m_read_data !== want.rd) begin
                        $display("%0t: read_data expected %0h actual %0h",
                                 $time, want.rd, m_read_data);
                        err_count++;
                    end
                end
            end
            if (calm) begin
                m_ready <= 1'b1;
            end else if (stall_left == 0) begin
                m_ready    <= $urandom_range(0, 1);
                stall_left <= $urandom_range(1, 10);
            end else begin
                stall_left <= stall_left - 1;
            end
        end
    end

endmodule

// File: hole_allocator_with_paging.f
hw/rtl/hap_pkg.sv
hw/rtl/hap_ram.sv
hw/rtl/hole_allocator_with_paging.sv
sim/testbench.sv
